/* rtl/wpm_pkg.sv */
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

  localparam logic [7:0] SYM_ANY  = 8'd63;
  localparam logic [7:0] SYM_STAR = 8'd42;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_TEXT    = 2'd2,
    FUNC_RESTART = 2'd3
  } wpm_func_t;

  // One-hot operation strobes, raised only in the cycle a request is processed.
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic restart;
  } wpm_ctrl_t;

endpackage

/* rtl/wpm_in_if.sv */
// Request channel interface: operation and character byte.
interface wpm_in_if import wpm_pkg::*; ();
  logic      valid;
  logic      ready;
  wpm_func_t func;
  logic [7:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

/* rtl/wpm_out_if.sv */
// Result channel interface: match, overflow and empty-text flags.
interface wpm_out_if import wpm_pkg::*; ();
  logic valid;
  logic ready;
  logic match;
  logic overflow;
  logic empty_text;

  modport source (output valid, output match, output overflow, output empty_text,
                  input ready);
  modport sink   (input valid, input match, input overflow, input empty_text,
                  output ready);
endinterface

/* rtl/wpm_pat.sv */
// Pattern store: characters, star/any decode, length and overflow flag.
module wpm_pat import wpm_pkg::*; #(
  parameter int PAT_LEN = 32,
  localparam int LEN_W = $clog2(PAT_LEN + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpm_ctrl_t          ctrl,
  input  logic [7:0]         symbol,
  output logic [LEN_W-1:0]   len,
  output logic               ovf,
  output logic [PAT_LEN-1:0] star_cur,
  output logic [PAT_LEN-1:0] star_upd,
  output logic [PAT_LEN-1:0] hit
);

  logic [7:0]         char_r [PAT_LEN];
  logic [PAT_LEN-1:0] star_r;
  logic [PAT_LEN-1:0] any_r;
  logic [PAT_LEN-1:0] live;
  logic [LEN_W-1:0]   len_r;
  logic               ovf_r;
  logic               full;

  assign full = (len_r == LEN_W'(PAT_LEN));
  assign len  = len_r;
  assign ovf  = ovf_r;

  // Entries are written only at the current length; no reset on the contents.
  always_ff @(posedge clk) begin
    for (int p = 0; p < PAT_LEN; p++) begin
      if (ctrl.append && !full && (len_r == LEN_W'(p))) begin
        char_r[p] <= symbol;
        star_r[p] <= (symbol == SYM_STAR);
        any_r[p]  <= (symbol == SYM_ANY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (ctrl.clear) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (ctrl.append) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        len_r <= len_r + LEN_W'(1);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PAT_LEN; p++) begin
      live[p]     = (LEN_W'(p) < len_r);
      star_cur[p] = live[p] & star_r[p];
      hit[p]      = live[p] & ~star_r[p] & (any_r[p] | (char_r[p] == symbol));
    end
  end

  // Star mask as it stands once this request's pattern edit has landed.
  always_comb begin
    star_upd = star_cur;
    if (ctrl.clear) begin
      star_upd = '0;
    end else if (ctrl.append && !full) begin
      for (int p = 0; p < PAT_LEN; p++) begin
        if (len_r == LEN_W'(p)) star_upd[p] = (symbol == SYM_STAR);
      end
    end
  end

endmodule

/* rtl/wpm_track.sv */
// Reached-position set: a text step, or position zero for other requests, plus star closure through a carry chain.
module wpm_track import wpm_pkg::*; #(
  parameter int PAT_LEN = 32,
  localparam int LEN_W = $clog2(PAT_LEN + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wpm_ctrl_t          ctrl,
  input  logic [LEN_W-1:0]   len,
  input  logic [PAT_LEN-1:0] star_cur,
  input  logic [PAT_LEN-1:0] star_upd,
  input  logic [PAT_LEN-1:0] hit,
  output logic               match
);

  logic [PAT_LEN:0] reached_r;
  logic [PAT_LEN:0] reached_nxt;
  logic [PAT_LEN:0] step;
  logic [PAT_LEN:0] seed;
  logic [PAT_LEN:0] smask;
  logic [PAT_LEN:0] gen;
  logic [PAT_LEN:0] carry;

  always_comb begin
    // A reached star stays put; a matched plain/any position moves up one.
    step = {1'b0, reached_r[PAT_LEN-1:0] & star_cur} |
           {reached_r[PAT_LEN-1:0] & hit, 1'b0};
    if (ctrl.text) begin
      seed  = step;
      smask = {1'b0, star_cur};
    end else begin
      seed  = (PAT_LEN + 1)'(1);
      smask = ctrl.restart ? {1'b0, star_cur} : {1'b0, star_upd};
    end
    // Closure: reached star generates, star run propagates -> adder carries.
    gen         = seed & smask;
    carry       = (smask + gen) ^ smask ^ gen;
    reached_nxt = seed | carry;
  end

  assign match = reached_nxt[len];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= (PAT_LEN + 1)'(1);
    end else if (ctrl.clear || ctrl.append || ctrl.text || ctrl.restart) begin
      reached_r <= reached_nxt;
    end
  end

endmodule

/* rtl/wildcard_pattern_matcher.sv */
// Wildcard matcher top: request register, pattern store, tracker, result register.
// Requests pass through the request register; results land in the output register.
// One request per cycle while no result is held up; star closure is one carry chain.
// Clear and append requests produce no result and never wait on the result side.
// Reset: empty pattern, overflow clear, position zero reached, both channels idle.
// Pattern characters are not cleared by reset; only entries below the length are used.
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int PAT_LEN = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  wpm_in_if.sink   in_req,
  wpm_out_if.source out_res
);

  localparam int LEN_W = $clog2(PAT_LEN + 1);

  logic       s1_valid_r;
  wpm_func_t  s1_func_r;
  logic [7:0] s1_sym_r;
  logic       s1_fire;
  logic       s1_has_res;
  logic       out_free;
  wpm_ctrl_t  ctrl;

  logic       out_valid_r;
  logic       match_r;
  logic       overflow_r;
  logic       empty_r;

  logic [LEN_W-1:0]   pat_len;
  logic               pat_ovf;
  logic [PAT_LEN-1:0] star_cur;
  logic [PAT_LEN-1:0] star_upd;
  logic [PAT_LEN-1:0] hit;
  logic               pos_match;

  assign s1_has_res = (s1_func_r == FUNC_TEXT) || (s1_func_r == FUNC_RESTART);
  assign out_free   = !out_valid_r || out_res.ready;
  assign s1_fire    = s1_valid_r && (!s1_has_res || out_free);
  assign in_req.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_func_r <= in_req.func;
      s1_sym_r  <= in_req.symbol;
    end
  end

  always_comb begin
    ctrl = '0;
    if (s1_fire) begin
      unique case (s1_func_r)
        FUNC_CLEAR:   ctrl.clear   = 1'b1;
        FUNC_APPEND:  ctrl.append  = 1'b1;
        FUNC_TEXT:    ctrl.text    = 1'b1;
        FUNC_RESTART: ctrl.restart = 1'b1;
        default:      ctrl = '0;
      endcase
    end
  end

  wpm_pat #(.PAT_LEN(PAT_LEN)) u_pat (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .symbol   (s1_sym_r),
    .len      (pat_len),
    .ovf      (pat_ovf),
    .star_cur (star_cur),
    .star_upd (star_upd),
    .hit      (hit)
  );

  wpm_track #(.PAT_LEN(PAT_LEN)) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .len      (pat_len),
    .star_cur (star_cur),
    .star_upd (star_upd),
    .hit      (hit),
    .match    (pos_match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Text and restart leave length and overflow untouched, so current values hold.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_res) begin
      match_r    <= pos_match && !pat_ovf;
      overflow_r <= pat_ovf;
      empty_r    <= ctrl.restart;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.match      = match_r;
  assign out_res.overflow   = overflow_r;
  assign out_res.empty_text = empty_r;

  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.match && out_res.overflow))
    else $error("match reported with overflow set");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |-> !(s1_fire && s1_has_res))
    else $error("result register overwritten while stalled");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pat_len <= LEN_W'(PAT_LEN))
    else $error("pattern length beyond store capacity");

  a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (!pat_ovf && (pat_len == '0)))
    else $error("clear did not empty the pattern");

endmodule

/* bench/wildcard_pattern_matcher_test.sv */
// Self-checking testbench for the wildcard pattern matcher: directed and random requests.
module wildcard_pattern_matcher_test;
  import wpm_pkg::*;

  localparam int PAT_LEN      = 32;
  localparam int MAX_CYCLES   = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_REQS  = 700;

  typedef struct packed {
    wpm_func_t  func;
    logic [7:0] symbol;
  } request_t;

  typedef struct packed {
    logic match;
    logic overflow;
    logic empty_text;
  } flags_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wpm_in_if  in_req ();
  wpm_out_if out_res ();

  wildcard_pattern_matcher #(.PAT_LEN(PAT_LEN)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #5 clk = ~clk;

  request_t         pending_reqs[$];
  flags_t           expected_flags[$];
  logic [7:0]       pat_chars[PAT_LEN];
  logic [5:0]       pat_len;
  logic [PAT_LEN:0] reached;
  logic             pat_overflow;
  logic             in_taken = 1'b0;
  int               reqs_sent = 0;
  int               total_reqs = 0;
  int               error_count = 0;
  int               cycle_count = 0;

  // Star positions pass their reach on to the next position, rippling upward.
  function automatic logic [PAT_LEN:0] close_stars(logic [PAT_LEN:0] set);
    for (int p = 0; p < PAT_LEN; p++) begin
      if (p < pat_len && set[p] && pat_chars[p] == SYM_STAR) set[p+1] = 1'b1;
    end
    return set;
  endfunction

  task automatic predict_request(request_t req);
    logic [PAT_LEN:0] advanced;
    flags_t           flags;
    advanced = '0;
    flags = '0;
    case (req.func)
      FUNC_CLEAR: begin
        pat_len = '0;
        pat_overflow = 1'b0;
        reached = close_stars((PAT_LEN + 1)'(1));
      end
      FUNC_APPEND: begin
        if (pat_len < PAT_LEN) begin
          pat_chars[pat_len] = req.symbol;
          pat_len = pat_len + 6'd1;
        end else begin
          pat_overflow = 1'b1;
        end
        reached = close_stars((PAT_LEN + 1)'(1));
      end
      FUNC_TEXT: begin
        for (int p = 0; p < PAT_LEN; p++) begin
          if (p < pat_len && reached[p]) begin
            if (pat_chars[p] == SYM_STAR) advanced[p] = 1'b1;
            else if (pat_chars[p] == SYM_ANY || pat_chars[p] == req.symbol)
              advanced[p+1] = 1'b1;
          end
        end
        reached = close_stars(advanced);
      end
      default: begin
        reached = close_stars((PAT_LEN + 1)'(1));
        flags.empty_text = 1'b1;
      end
    endcase
    if (req.func == FUNC_TEXT || req.func == FUNC_RESTART) begin
      flags.match = !pat_overflow && reached[pat_len];
      flags.overflow = pat_overflow;
      expected_flags.push_back(flags);
    end
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : monitor
    flags_t want;
    in_taken <= rst_n && in_req.valid && in_req.ready;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        if (expected_flags.size() == 0) begin
          $error("result with no request waiting for it");
          error_count++;
        end else begin
          want = expected_flags.pop_front();
          if (out_res.match !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, out_res.match);
            error_count++;
          end
          if (out_res.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_res.overflow);
            error_count++;
          end
          if (out_res.empty_text !== want.empty_text) begin
            $error("empty_text: expected %0b, got %0b", want.empty_text, out_res.empty_text);
            error_count++;
          end
        end
      end
      if (in_req.valid && in_req.ready) predict_request('{in_req.func, in_req.symbol});
    end
  end

  always @(negedge clk) begin : driver
    request_t req;
    int       idle_pct;
    int       stall_pct;
    if (reqs_sent < total_reqs / 3) begin
      idle_pct = 11;
      stall_pct = 63;
    end else if (reqs_sent < 2 * total_reqs / 3) begin
      idle_pct = 63;
      stall_pct = 11;
    end else begin
      idle_pct = 0;
      stall_pct = 0;
    end
    if (rst_n) begin
      if (!in_req.valid || in_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req = pending_reqs.pop_front();
          in_req.valid  <= 1'b1;
          in_req.func   <= req.func;
          in_req.symbol <= req.symbol;
          reqs_sent++;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
      out_res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(wpm_func_t func, logic [7:0] symbol);
    pending_reqs.push_back('{func, symbol});
  endtask

  task automatic load_pattern(string pat);
    push_req(FUNC_CLEAR, 8'($urandom));
    for (int i = 0; i < pat.len(); i++) push_req(FUNC_APPEND, pat[i]);
  endtask

  task automatic send_text(string txt);
    push_req(FUNC_RESTART, 8'($urandom));
    for (int i = 0; i < txt.len(); i++) push_req(FUNC_TEXT, txt[i]);
  endtask

  // Small alphabet so that wildcards and literals collide often.
  function automatic logic [7:0] pick_char(bit wild);
    case ($urandom_range(9))
      0, 1:    return wild ? SYM_STAR : 8'h61;
      2, 3:    return wild ? SYM_ANY : 8'h62;
      4:       return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  // One pattern, then a few texts: mostly matching ones, some broken or random.
  task automatic random_session();
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         plen;
    int         kind;
    plen = ($urandom_range(15) == 0) ? $urandom_range(PAT_LEN + 3, PAT_LEN - 2)
                                     : $urandom_range(6);
    push_req(FUNC_CLEAR, 8'($urandom));
    for (int i = 0; i < plen; i++) begin
      pat.push_back(pick_char(1'b1));
      push_req(FUNC_APPEND, pat[i]);
    end
    repeat ($urandom_range(4, 1)) begin
      kind = $urandom_range(19);
      txt.delete();
      if (kind < 15) begin
        foreach (pat[i]) begin
          if (i >= PAT_LEN) break;
          if (pat[i] == SYM_STAR) repeat ($urandom_range(2)) txt.push_back(pick_char(1'b0));
          else if (pat[i] == SYM_ANY) txt.push_back(8'($urandom));
          else txt.push_back(pat[i]);
        end
        if (kind >= 12) begin
          if (txt.size() != 0 && kind != 14) txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
          else txt.push_back(pick_char(1'b0));
        end
      end else begin
        repeat ($urandom_range(6)) txt.push_back(pick_char(1'b0));
      end
      // now and then the text carries on from the previous one
      if (kind != 19) push_req(FUNC_RESTART, 8'($urandom));
      foreach (txt[i]) begin
        push_req(FUNC_TEXT, txt[i]);
        if ($urandom_range(40) == 0) begin
          pat.push_back(pick_char(1'b1));
          push_req(FUNC_APPEND, pat[$]);
        end
      end
    end
  endtask

  initial begin
    in_req.valid  = 1'b0;
    in_req.func   = FUNC_CLEAR;
    in_req.symbol = '0;
    out_res.ready = 1'b0;
    foreach (pat_chars[i]) pat_chars[i] = '0;
    pat_len = '0;
    pat_overflow = 1'b0;
    reached = (PAT_LEN + 1)'(1);

    // empty pattern against empty and non-empty text
    send_text("a");
    // trailing star matches an empty run
    load_pattern("*");
    send_text("");
    push_req(FUNC_TEXT, 8'hFF);
    // wildcards in text are plain characters
    load_pattern("a?*");
    send_text("ab*?");
    // an append in the middle of a text restarts it
    push_req(FUNC_CLEAR, 8'h00);
    push_req(FUNC_APPEND, 8'h00);
    push_req(FUNC_TEXT, 8'h00);
    push_req(FUNC_APPEND, 8'hFF);
    push_req(FUNC_TEXT, 8'h00);
    push_req(FUNC_TEXT, 8'hFF);
    // full pattern, then an append past the end, then a clear
    push_req(FUNC_CLEAR, 8'hFF);
    repeat (PAT_LEN + 1) push_req(FUNC_APPEND, SYM_STAR);
    send_text("");
    load_pattern("");
    send_text("");

    while (pending_reqs.size() < RANDOM_REQS + 40) random_session();
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_reqs.size() != 0 || (in_req.valid && !in_taken));
    while (expected_flags.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* wildcard_pattern_matcher.f */
rtl/wpm_pkg.sv
rtl/wpm_in_if.sv
rtl/wpm_out_if.sv
rtl/wpm_pat.sv
rtl/wpm_track.sv
rtl/wildcard_pattern_matcher.sv
bench/wildcard_pattern_matcher_test.sv
